@@ rtl/prs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_pkg: shared types and constants of the particle ring
// Fixed-point formats, motion constants and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int POS_W = 22;
  localparam int VEL_W = 16;
  localparam int RAD_W = 14;
  localparam int ALP_W = 8;
  localparam int CFG_W = 12;

  localparam logic signed [POS_W-1:0] POS_MAX = 22'sd2097151;
  localparam logic signed [POS_W-1:0] POS_MIN = -22'sd2097152;
  localparam logic signed [VEL_W-1:0] VEL_MAX = 16'sd32767;
  localparam logic signed [VEL_W-1:0] VEL_MIN = -16'sd32768;
  localparam logic [RAD_W-1:0] RAD_MAX = 14'd16383;
  localparam logic [VEL_W-1:0] SMOKE_RISE = 16'd13;
  localparam logic [VEL_W-1:0] SPARK_FALL = 16'd51;
  localparam logic [RAD_W-1:0] SMOKE_GROW = 14'd128;
  localparam logic [RAD_W-1:0] SMOKE_R0 = 14'd1792;
  localparam logic [RAD_W-1:0] SPARK_R0 = 14'd640;
  localparam logic [ALP_W-1:0] ALPHA_FULL = 8'd255;
  localparam logic [ALP_W-1:0] ALPHA_FADE = 8'd4;
  localparam logic [ALP_W-1:0] ALPHA_MIN = 8'd4;
  localparam logic [CFG_W-1:0] WIDTH_RST = 12'd800;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd450;

  localparam logic MODE_EMIT = 1'b0;
  localparam logic MODE_FRAME = 1'b1;
  localparam logic KIND_SMOKE = 1'b0;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } pos_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic [RAD_W-1:0] r;
    logic [ALP_W-1:0] a;
    logic kind;
    logic alive;
  } mot_t;

  function automatic logic [14:0] qsine(input logic [6:0] d);
    logic [14:0] v;
    case (d)
      7'd0: v = 15'd0; 7'd1: v = 15'd286; 7'd2: v = 15'd572; 7'd3: v = 15'd857;
      7'd4: v = 15'd1143; 7'd5: v = 15'd1428; 7'd6: v = 15'd1713; 7'd7: v = 15'd1997;
      7'd8: v = 15'd2280; 7'd9: v = 15'd2563; 7'd10: v = 15'd2845; 7'd11: v = 15'd3126;
      7'd12: v = 15'd3406; 7'd13: v = 15'd3686; 7'd14: v = 15'd3964; 7'd15: v = 15'd4240;
      7'd16: v = 15'd4516; 7'd17: v = 15'd4790; 7'd18: v = 15'd5063; 7'd19: v = 15'd5334;
      7'd20: v = 15'd5604; 7'd21: v = 15'd5872; 7'd22: v = 15'd6138; 7'd23: v = 15'd6402;
      7'd24: v = 15'd6664; 7'd25: v = 15'd6924; 7'd26: v = 15'd7182; 7'd27: v = 15'd7438;
      7'd28: v = 15'd7692; 7'd29: v = 15'd7943; 7'd30: v = 15'd8192; 7'd31: v = 15'd8438;
      7'd32: v = 15'd8682; 7'd33: v = 15'd8923; 7'd34: v = 15'd9162; 7'd35: v = 15'd9397;
      7'd36: v = 15'd9630; 7'd37: v = 15'd9860; 7'd38: v = 15'd10087; 7'd39: v = 15'd10311;
      7'd40: v = 15'd10531; 7'd41: v = 15'd10749; 7'd42: v = 15'd10963; 7'd43: v = 15'd11174;
      7'd44: v = 15'd11381; 7'd45: v = 15'd11585; 7'd46: v = 15'd11786; 7'd47: v = 15'd11982;
      7'd48: v = 15'd12176; 7'd49: v = 15'd12365; 7'd50: v = 15'd12551; 7'd51: v = 15'd12733;
      7'd52: v = 15'd12911; 7'd53: v = 15'd13085; 7'd54: v = 15'd13255; 7'd55: v = 15'd13421;
      7'd56: v = 15'd13583; 7'd57: v = 15'd13741; 7'd58: v = 15'd13894; 7'd59: v = 15'd14044;
      7'd60: v = 15'd14189; 7'd61: v = 15'd14330; 7'd62: v = 15'd14466; 7'd63: v = 15'd14598;
      7'd64: v = 15'd14726; 7'd65: v = 15'd14849; 7'd66: v = 15'd14968; 7'd67: v = 15'd15082;
      7'd68: v = 15'd15191; 7'd69: v = 15'd15296; 7'd70: v = 15'd15396; 7'd71: v = 15'd15491;
      7'd72: v = 15'd15582; 7'd73: v = 15'd15668; 7'd74: v = 15'd15749; 7'd75: v = 15'd15826;
      7'd76: v = 15'd15897; 7'd77: v = 15'd15964; 7'd78: v = 15'd16026; 7'd79: v = 15'd16083;
      7'd80: v = 15'd16135; 7'd81: v = 15'd16182; 7'd82: v = 15'd16225; 7'd83: v = 15'd16262;
      7'd84: v = 15'd16294; 7'd85: v = 15'd16322; 7'd86: v = 15'd16344; 7'd87: v = 15'd16362;
      7'd88: v = 15'd16374; 7'd89: v = 15'd16382; 7'd90: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // Angle in 0..719 reduced to 0..359, then folded to a quadrant.
  function automatic logic signed [15:0] sine14(input logic [9:0] ang);
    logic [9:0] a;
    logic [14:0] m;
    a = (ang >= 10'd360) ? ang - 10'd360 : ang;
    if (a <= 10'd90) m = qsine(a[6:0]);
    else if (a <= 10'd180) m = qsine(7'(10'd180 - a));
    else if (a <= 10'd270) m = qsine(7'(a - 10'd180));
    else m = qsine(7'(10'd360 - a));
    return (a <= 10'd180) ? $signed({1'b0, m}) : -$signed({1'b0, m});
  endfunction

endpackage

@@ rtl/prs_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_alu: shared saturating adder and compare unit
// One signed add with saturation to selectable bounds, plus a less-than flag.
// ----------------------------------------------------------------------------
module prs_alu (
  input  logic signed [24:0] op_a,
  input  logic signed [24:0] op_b,
  input  logic signed [24:0] sat_hi,
  input  logic signed [24:0] sat_lo,
  output logic signed [24:0] sum,
  output logic               a_lt_b
);

  logic signed [25:0] raw;

  always_comb begin
    raw = 26'(op_a) + 26'(op_b);
    if (raw > 26'(sat_hi)) sum = sat_hi;
    else if (raw < 26'(sat_lo)) sum = sat_lo;
    else sum = raw[24:0];
    a_lt_b = op_a < op_b;
  end

endmodule

@@ rtl/prs_veldiv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_veldiv: emit velocity from speed and trig value
// Computes round(step*|t|/320) as a shift by 64 and a reciprocal multiply by 1/5.
// ----------------------------------------------------------------------------
module prs_veldiv (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [3:0]               step,
  input  logic signed [15:0]       trig,
  output logic                     done,
  output logic signed [15:0]       vel
);

  logic [17:0]   num_r, num_nxt;
  logic          busy_r;
  logic          neg_r;
  logic [14:0]   mag;
  logic [11:0]   q64;
  logic [25:0]   prod;
  logic [9:0]    quo;

  always_comb begin
    mag = trig[15] ? 15'(-trig) : 15'(trig);
    num_nxt = {14'd0, step} * {3'd0, mag} + 18'd160;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= start;
    end
    if (start) begin
      num_r <= num_nxt;
      neg_r <= trig[15];
    end
  end

  // floor(n/320) = floor(floor(n/64)/5); 13108/65536 is exact for n/64 below 16384
  assign q64 = num_r[17:6];
  assign prod = 26'(q64) * 26'd13108;
  assign quo = prod[25:16];

  assign done = busy_r;
  assign vel = neg_r ? -$signed({6'd0, quo}) : $signed({6'd0, quo});

endmodule

@@ rtl/particle_ring_simulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_ring_simulator: ring of particles updated one slot at a time
// Emits particles into a ring and advances/lists them once per frame.
// ----------------------------------------------------------------------------
// An emit word computes the x and then the y velocity (shift and reciprocal
// multiply), writes the slot and then presents the result word until taken. A
// frame word updates each smoke or spark slot between tail and head (one
// memory read and load, eight or seven steps of the shared saturating
// adder/compare unit, one alpha step for smoke, one write), then skips the
// dead slots at the tail, then lists each slot from tail to head and can
// stall on the output; each live particle is held until the next live one is
// read so the final word carries last. Ring slots hold up to RING_DEPTH-1
// particles; the stores are never cleared.
module particle_ring_simulator #(
  parameter int RING_DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [11:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  logic signed [21:0]       in_emit_x,
  input  logic signed [21:0]       in_emit_y,
  input  logic                     in_kind,
  input  logic [3:0]               in_speed_step,
  input  logic [8:0]               in_angle_deg,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_accepted,
  output logic                     out_present,
  output logic signed [21:0]       out_pos_x,
  output logic signed [21:0]       out_pos_y,
  output logic [13:0]              out_radius,
  output logic [7:0]               out_alpha,
  output logic                     out_out_kind,
  output logic                     out_last
);

  localparam int AW = $clog2(RING_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE, S_DIVX, S_DIVY, S_WRITE, S_RD, S_RDW, S_X, S_VY, S_Y, S_R, S_AL,
    S_C0, S_C1, S_C2, S_C3, S_WB, S_SKIP, S_SKW, S_LRD, S_LRW, S_LOUT, S_OUT
  } state_t;

  state_t state_r;
  logic [AW-1:0] head_r, tail_r, idx_r;
  logic [11:0] width_r, height_r;
  logic any_r;

  prs_pkg::pos_t pos_mem [RING_DEPTH];
  prs_pkg::mot_t mot_mem [RING_DEPTH];
  prs_pkg::pos_t prd_r, pw_r;
  prs_pkg::mot_t mrd_r, mw_r;
  logic [AW-1:0] raddr, waddr_r;
  logic we_r;

  logic in_kind_r;
  logic signed [21:0] ex_r, ey_r;
  logic [3:0] step_r;
  logic [8:0] ang_r;
  logic signed [15:0] vx_r;

  logic signed [24:0] op_a, op_b, sat_hi, sat_lo, sum;
  logic lt;
  logic dv_start, dv_done;
  logic [3:0] dv_step;
  logic signed [15:0] dv_trig, dv_vel;
  logic [AW-1:0] head_inc;
  logic signed [24:0] rad25;

  prs_alu u_alu (.op_a(op_a), .op_b(op_b), .sat_hi(sat_hi), .sat_lo(sat_lo),
                 .sum(sum), .a_lt_b(lt));

  prs_veldiv u_div (.clk(clk), .rst_n(rst_n), .start(dv_start), .step(dv_step),
                    .trig(dv_trig), .done(dv_done), .vel(dv_vel));

  assign head_inc = (head_r == AW'(RING_DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign in_ready = state_r == S_IDLE;
  assign dv_start = (state_r == S_IDLE && in_valid && in_mode == prs_pkg::MODE_EMIT
                     && head_inc != tail_r) || (state_r == S_DIVX && dv_done);
  assign dv_step = (state_r == S_IDLE) ? in_speed_step : step_r;
  assign dv_trig = (state_r == S_IDLE) ? prs_pkg::sine14(10'(in_angle_deg) + 10'd90)
                                       : prs_pkg::sine14(10'(ang_r));
  // look at the tail slot while skipping dead ones
  assign raddr = (state_r == S_SKIP) ? tail_r : idx_r;
  assign rad25 = 25'(mw_r.r);

  // shared unit operand select
  always_comb begin
    op_a = '0; op_b = '0;
    sat_hi = 25'(prs_pkg::POS_MAX); sat_lo = 25'(prs_pkg::POS_MIN);
    case (state_r)
      S_X: begin op_a = 25'(pw_r.x); op_b = 25'(mw_r.vx); end
      S_VY: begin
        op_a = 25'(mw_r.vy);
        op_b = (mw_r.kind == prs_pkg::KIND_SMOKE) ? -25'(prs_pkg::SMOKE_RISE)
                                                   : 25'(prs_pkg::SPARK_FALL);
        sat_hi = 25'(prs_pkg::VEL_MAX); sat_lo = 25'(prs_pkg::VEL_MIN);
      end
      S_Y: begin op_a = 25'(pw_r.y); op_b = 25'(mw_r.vy); end
      S_R: begin
        op_a = 25'(mw_r.r); op_b = 25'(prs_pkg::SMOKE_GROW);
        sat_hi = 25'(prs_pkg::RAD_MAX); sat_lo = '0;
      end
      S_C0: begin op_a = 25'(pw_r.x); op_b = -rad25; end
      S_C1: begin op_a = {5'd0, width_r, 8'd0} + rad25; op_b = 25'(pw_r.x); end
      S_C2: begin op_a = 25'(pw_r.y); op_b = -rad25; end
      S_C3: begin op_a = {5'd0, height_r, 8'd0} + rad25; op_b = 25'(pw_r.y); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_r) begin
      pos_mem[waddr_r] <= pw_r;
      mot_mem[waddr_r] <= mw_r;
    end
    prd_r <= pos_mem[raddr];
    mrd_r <= mot_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0; tail_r <= '0; idx_r <= '0;
      width_r <= prs_pkg::WIDTH_RST; height_r <= prs_pkg::HEIGHT_RST;
      out_valid <= 1'b0; we_r <= 1'b0; any_r <= 1'b0;
    end else begin
      we_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == prs_pkg::CFG_WIDTH) width_r <= cfg_data;
        else height_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: if (in_valid) begin
          ex_r <= in_emit_x; ey_r <= in_emit_y; in_kind_r <= in_kind;
          step_r <= in_speed_step; ang_r <= in_angle_deg;
          if (in_mode == prs_pkg::MODE_EMIT) begin
            if (head_inc != tail_r) state_r <= S_DIVX;
            else begin
              out_accepted <= 1'b0; out_present <= 1'b0; out_pos_x <= '0;
              out_pos_y <= '0; out_radius <= '0; out_alpha <= '0;
              out_out_kind <= 1'b0; out_last <= 1'b1; out_valid <= 1'b1;
              state_r <= S_OUT;
            end
          end else begin
            idx_r <= tail_r;
            state_r <= S_RD;
          end
        end
        S_DIVX: if (dv_done) begin vx_r <= dv_vel; state_r <= S_DIVY; end
        S_DIVY: if (dv_done) begin
          pw_r.x <= ex_r; pw_r.y <= ey_r;
          mw_r.vx <= vx_r; mw_r.vy <= dv_vel; mw_r.kind <= in_kind_r;
          mw_r.alive <= 1'b1; mw_r.a <= prs_pkg::ALPHA_FULL;
          mw_r.r <= in_kind_r ? prs_pkg::SPARK_R0 : prs_pkg::SMOKE_R0;
          waddr_r <= head_r; we_r <= 1'b1;
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          head_r <= head_inc;
          out_accepted <= 1'b1; out_present <= 1'b0; out_pos_x <= '0;
          out_pos_y <= '0; out_radius <= '0; out_alpha <= '0;
          out_out_kind <= 1'b0; out_last <= 1'b1; out_valid <= 1'b1;
          state_r <= S_OUT;
        end
        S_RD: begin
          if (idx_r == head_r) begin
            state_r <= S_SKIP;
          end else state_r <= S_RDW;
        end
        S_RDW: begin pw_r <= prd_r; mw_r <= mrd_r; state_r <= S_X; end
        S_X: begin pw_r.x <= sum[21:0]; state_r <= S_VY; end
        S_VY: begin mw_r.vy <= sum[15:0]; state_r <= S_Y; end
        S_Y: begin
          pw_r.y <= sum[21:0];
          state_r <= (mw_r.kind == prs_pkg::KIND_SMOKE) ? S_R : S_C0;
        end
        S_R: begin mw_r.r <= sum[13:0]; state_r <= S_AL; end
        S_AL: begin
          mw_r.a <= mw_r.a - prs_pkg::ALPHA_FADE;
          if (mw_r.a - prs_pkg::ALPHA_FADE < prs_pkg::ALPHA_MIN) mw_r.alive <= 1'b0;
          state_r <= S_C0;
        end
        S_C0: begin if (lt) mw_r.alive <= 1'b0; state_r <= S_C1; end
        S_C1: begin if (lt) mw_r.alive <= 1'b0; state_r <= S_C2; end
        S_C2: begin if (lt) mw_r.alive <= 1'b0; state_r <= S_C3; end
        S_C3: begin if (lt) mw_r.alive <= 1'b0; state_r <= S_WB; end
        S_WB: begin
          waddr_r <= idx_r; we_r <= 1'b1;
          idx_r <= (idx_r == AW'(RING_DEPTH - 1)) ? '0 : idx_r + AW'(1);
          state_r <= S_RD;
        end
        // advance tail over dead slots
        S_SKIP: begin
          idx_r <= tail_r;
          if (tail_r == head_r) begin
            any_r <= 1'b0; state_r <= S_LRD;
          end else state_r <= S_SKW;
        end
        S_SKW: begin
          if (mrd_r.alive) begin
            any_r <= 1'b0; state_r <= S_LRD;
          end else begin
            tail_r <= (tail_r == AW'(RING_DEPTH - 1)) ? '0 : tail_r + AW'(1);
            state_r <= S_SKIP;
          end
        end
        S_LRD: begin
          if (idx_r == head_r) begin
            if (!any_r) begin
              out_accepted <= 1'b0; out_present <= 1'b0; out_pos_x <= '0;
              out_pos_y <= '0; out_radius <= '0; out_alpha <= '0;
              out_out_kind <= 1'b0; out_last <= 1'b1; out_valid <= 1'b1;
              state_r <= S_OUT;
            end else if (!out_valid || out_ready) begin
              // release the held particle as the final word
              out_accepted <= 1'b0; out_present <= 1'b1;
              out_pos_x <= pw_r.x; out_pos_y <= pw_r.y;
              out_radius <= mw_r.r; out_alpha <= mw_r.a;
              out_out_kind <= mw_r.kind; out_last <= 1'b1; out_valid <= 1'b1;
              state_r <= S_OUT;
            end
          end else begin
            if (out_ready) out_valid <= 1'b0;
            state_r <= S_LRW;
          end
        end
        S_LRW: begin
          if (out_ready) out_valid <= 1'b0;
          state_r <= S_LOUT;
        end
        // hold each live particle until the next one shows it is not the last
        S_LOUT: begin
          if (!mrd_r.alive) begin
            if (out_ready) out_valid <= 1'b0;
            idx_r <= (idx_r == AW'(RING_DEPTH - 1)) ? '0 : idx_r + AW'(1);
            state_r <= S_LRD;
          end else if (!any_r) begin
            if (out_ready) out_valid <= 1'b0;
            pw_r <= prd_r; mw_r <= mrd_r; any_r <= 1'b1;
            idx_r <= (idx_r == AW'(RING_DEPTH - 1)) ? '0 : idx_r + AW'(1);
            state_r <= S_LRD;
          end else if (!out_valid || out_ready) begin
            out_accepted <= 1'b0; out_present <= 1'b1;
            out_pos_x <= pw_r.x; out_pos_y <= pw_r.y;
            out_radius <= mw_r.r; out_alpha <= mw_r.a;
            out_out_kind <= mw_r.kind; out_last <= 1'b0; out_valid <= 1'b1;
            pw_r <= prd_r; mw_r <= mrd_r;
            idx_r <= (idx_r == AW'(RING_DEPTH - 1)) ? '0 : idx_r + AW'(1);
            state_r <= S_LRD;
          end
        end
        S_OUT: if (out_ready) begin out_valid <= 1'b0; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while a word is pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid) |-> out_last) else $error("final word without last");
  a_no_full: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == S_WRITE) |-> head_r != tail_r) else $error("ring overflow");

endmodule
